// ===== rtl/bdi_pkg.sv =====
// shared types, constants and fixed-point helpers of the boundary displacement integrator
package bdi_pkg;

  // fixed-point format and function count
  localparam int NUM_FUNCS  = 3;
  localparam int FRAC_BITS  = 16;

  // field widths
  localparam int DATA_W     = 32;
  localparam int LEN_W      = 31;
  localparam int MAG_W      = 31;
  localparam int LIMIT_W    = FRAC_BITS + 1;
  localparam int SEL_W      = 2;
  localparam int ACC_W      = 2 * DATA_W;
  localparam int WIDE_W     = 2 * DATA_W - FRAC_BITS + 2;
  localparam int CFG_ADDR_W = 3;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W  = ((4 * DATA_W + LEN_W + 7) / 8) * 8;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = ((DATA_W + MAG_W + ACC_W + 7) / 8) * 8;

  // reset values of the registers that are not zero
  localparam logic [LIMIT_W-1:0] MOVE_LIMIT_RESET = LIMIT_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0]  SCALE_RESET      = DATA_W'(1) << FRAC_BITS;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WEIGHT_OBJECTIVE = 3'd0,
    REG_WEIGHT_FIRST     = 3'd1,
    REG_WEIGHT_SECOND    = 3'd2,
    REG_MOVE_LIMIT       = 3'd3,
    REG_CAP_ENABLE       = 3'd4,
    REG_INTEGRAL_SCALE   = 3'd5,
    REG_INTEGRAL_OFFSET  = 3'd6,
    REG_INTEGRAL_SELECT  = 3'd7
  } cfg_reg_t;

  // sensitivity that weights the integral
  typedef enum logic [SEL_W-1:0] {
    SEL_OBJECTIVE = 2'd0,
    SEL_FIRST     = 2'd1,
    SEL_SECOND    = 2'd2,
    SEL_NONE      = 2'd3
  } int_sel_t;

  // configuration register contents
  typedef struct packed {
    logic [DATA_W-1:0]  weight_objective;
    logic [DATA_W-1:0]  weight_first;
    logic [DATA_W-1:0]  weight_second;
    logic [LIMIT_W-1:0] move_limit;
    logic               cap_enable;
    logic [DATA_W-1:0]  integral_scale;
    logic [DATA_W-1:0]  integral_offset;
    int_sel_t           integral_select;
  } cfg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_OBJ,
    ST_MUL_FIRST,
    ST_MUL_SECOND,
    ST_MUL_LEN,
    ST_CLAMP,
    ST_MUL_SCALE,
    ST_LOAD_A,
    ST_MUL_TERM,
    ST_ACCUM,
    ST_OUTPUT
  } state_t;

  // operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_W_OBJ,
    MUL_W_FIRST,
    MUL_W_SECOND,
    MUL_SEL_LEN,
    MUL_SCALE_DISP,
    MUL_A_B
  } mul_op_t;

  // use of the registered product
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_WIDE_LOAD,
    ACC_WIDE_ADD,
    ACC_LOAD_A,
    ACC_LOAD_B
  } acc_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    clamp;
    logic    accum;
    logic    out_load;
  } cmd_t;

  // product shifted down by the fraction bits, rounded toward zero
  function automatic logic signed [ACC_W-1:0] qshift(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] bias;
    bias = {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{p[ACC_W-1]}}};
    return (p + bias) >>> FRAC_BITS;
  endfunction

  // saturate a wide value to the data width
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[ACC_W-1:DATA_W-1];
    all_zero = ~|v[ACC_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // saturating add on the accumulator width
  function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      return a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/bdi_cfg_regs.sv =====
// configuration register file of the boundary displacement integrator
module bdi_cfg_regs import bdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  output cfg_t                  cfg
);

  // register writes, one index per write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_objective <= '0;
      cfg.weight_first     <= '0;
      cfg.weight_second    <= '0;
      cfg.move_limit       <= MOVE_LIMIT_RESET;
      cfg.cap_enable       <= 1'b0;
      cfg.integral_scale   <= SCALE_RESET;
      cfg.integral_offset  <= '0;
      cfg.integral_select  <= SEL_OBJECTIVE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WEIGHT_OBJECTIVE: cfg.weight_objective <= cfg_wdata;
        REG_WEIGHT_FIRST:     cfg.weight_first     <= cfg_wdata;
        REG_WEIGHT_SECOND:    cfg.weight_second    <= cfg_wdata;
        REG_MOVE_LIMIT:       cfg.move_limit       <= cfg_wdata[LIMIT_W-1:0];
        REG_CAP_ENABLE:       cfg.cap_enable       <= cfg_wdata[0];
        REG_INTEGRAL_SCALE:   cfg.integral_scale   <= cfg_wdata;
        REG_INTEGRAL_OFFSET:  cfg.integral_offset  <= cfg_wdata;
        REG_INTEGRAL_SELECT:  cfg.integral_select  <= int_sel_t'(cfg_wdata[SEL_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bdi_ctrl.sv =====
// sequencing controller: steps one point through the shared multiplier
module bdi_ctrl import bdi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // output register can take a result
  assign out_free = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.mul_op   = MUL_W_OBJ;
    cmd.acc_op   = ACC_NONE;
    cmd.clamp    = 1'b0;
    cmd.accum    = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_MUL_OBJ;
        end
      end
      ST_MUL_OBJ: begin
        cmd.mul_op = MUL_W_OBJ;
        state_next = ST_MUL_FIRST;
      end
      ST_MUL_FIRST: begin
        cmd.mul_op = MUL_W_FIRST;
        cmd.acc_op = ACC_WIDE_LOAD;
        state_next = ST_MUL_SECOND;
      end
      ST_MUL_SECOND: begin
        cmd.mul_op = MUL_W_SECOND;
        cmd.acc_op = ACC_WIDE_ADD;
        state_next = ST_MUL_LEN;
      end
      ST_MUL_LEN: begin
        cmd.mul_op = MUL_SEL_LEN;
        cmd.acc_op = ACC_WIDE_ADD;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.acc_op = ACC_LOAD_B;
        cmd.clamp  = 1'b1;
        state_next = ST_MUL_SCALE;
      end
      ST_MUL_SCALE: begin
        cmd.mul_op = MUL_SCALE_DISP;
        state_next = ST_LOAD_A;
      end
      ST_LOAD_A: begin
        cmd.acc_op = ACC_LOAD_A;
        state_next = ST_MUL_TERM;
      end
      ST_MUL_TERM: begin
        cmd.mul_op = MUL_A_B;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bdi_datapath.sv =====
// datapath: point registers, shared multiplier, clamp, running sums and result register
module bdi_datapath import bdi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 s_tlast,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);

  // captured point
  logic signed [DATA_W-1:0] sens_objective;
  logic signed [DATA_W-1:0] sens_first;
  logic signed [DATA_W-1:0] sens_second;
  logic        [LEN_W-1:0]  seg_length;
  logic signed [DATA_W-1:0] low_limit;
  logic                     fixed_point_flag;
  logic                     domain_flag;
  logic                     last_point;

  // working registers
  logic signed [ACC_W-1:0]  prod;
  logic signed [WIDE_W-1:0] wide;
  logic signed [DATA_W-1:0] a_term;
  logic signed [DATA_W-1:0] b_term;
  logic signed [DATA_W-1:0] disp;
  logic                     side;
  logic signed [ACC_W-1:0]  integral_sum;
  logic        [MAG_W-1:0]  peak_magnitude;

  // combinational values
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [DATA_W-1:0] sel_sens;
  logic signed [WIDE_W-1:0] low_ext;
  logic signed [WIDE_W-1:0] limit_ext;
  logic signed [WIDE_W-1:0] clamped;
  logic                     side_hit;
  logic signed [DATA_W-1:0] disp_next;
  logic        [MAG_W-1:0]  mag;
  logic signed [ACC_W-1:0]  neg_offset;
  logic signed [ACC_W-1:0]  result;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sens_objective   <= s_tdata[DATA_W-1:0];
      sens_first       <= s_tdata[2*DATA_W-1:DATA_W];
      sens_second      <= s_tdata[3*DATA_W-1:2*DATA_W];
      seg_length       <= s_tdata[3*DATA_W+LEN_W-1:3*DATA_W];
      low_limit        <= s_tdata[4*DATA_W+LEN_W-1:3*DATA_W+LEN_W];
      fixed_point_flag <= s_tuser[0];
      domain_flag      <= s_tuser[1];
      last_point       <= s_tlast;
    end
  end

  // sensitivity picked for the integral
  always_comb begin
    unique case (cfg.integral_select)
      SEL_OBJECTIVE: sel_sens = sens_objective;
      SEL_FIRST:     sel_sens = sens_first;
      SEL_SECOND:    sel_sens = sens_second;
      SEL_NONE:      sel_sens = '0;
      default:       sel_sens = '0;
    endcase
  end

  // operand select of the shared multiplier; unused functions weigh zero
  always_comb begin
    unique case (cmd.mul_op)
      MUL_W_OBJ: begin
        mul_a = cfg.weight_objective;
        mul_b = sens_objective;
      end
      MUL_W_FIRST: begin
        mul_a = (NUM_FUNCS >= 2) ? cfg.weight_first : '0;
        mul_b = sens_first;
      end
      MUL_W_SECOND: begin
        mul_a = (NUM_FUNCS >= 3) ? cfg.weight_second : '0;
        mul_b = sens_second;
      end
      MUL_SEL_LEN: begin
        mul_a = sel_sens;
        mul_b = {1'b0, seg_length};
      end
      MUL_SCALE_DISP: begin
        mul_a = cfg.integral_scale;
        mul_b = disp;
      end
      MUL_A_B: begin
        mul_a = a_term;
        mul_b = b_term;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign prod_q = qshift(prod);

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // weighted sum and scaled terms
  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      ACC_NONE:      ;
      ACC_WIDE_LOAD: wide   <= prod_q[WIDE_W-1:0];
      ACC_WIDE_ADD:  wide   <= wide + prod_q[WIDE_W-1:0];
      ACC_LOAD_A:    a_term <= sat32(prod_q);
      ACC_LOAD_B:    b_term <= sat32(prod_q);
      default:       ;
    endcase
  end

  // side clamp, cap and saturation of the displacement
  assign low_ext   = {{(WIDE_W-DATA_W){low_limit[DATA_W-1]}}, low_limit};
  assign limit_ext = {{(WIDE_W-LIMIT_W){1'b0}}, cfg.move_limit};

  always_comb begin
    clamped  = wide;
    side_hit = 1'b0;
    if (domain_flag && (wide < low_ext)) begin
      clamped  = low_ext;
      side_hit = 1'b1;
    end
    if (cfg.cap_enable && (clamped > limit_ext)) begin
      clamped = limit_ext;
    end
    if (fixed_point_flag) begin
      disp_next = '0;
    end else begin
      disp_next = sat32({{(ACC_W-WIDE_W){clamped[WIDE_W-1]}}, clamped});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      disp <= disp_next;
      side <= side_hit && !fixed_point_flag;
    end
  end

  // magnitude of the displacement, saturated to the magnitude width
  always_comb begin
    if (disp == {1'b1, {(DATA_W-1){1'b0}}}) begin
      mag = '1;
    end else if (disp[DATA_W-1]) begin
      mag = MAG_W'(-disp);
    end else begin
      mag = disp[MAG_W-1:0];
    end
  end

  // final result with the offset taken off on the last point
  assign neg_offset = -({{(ACC_W-DATA_W){cfg.integral_offset[DATA_W-1]}}, cfg.integral_offset}
                        <<< FRAC_BITS);
  assign result     = last_point ? sat_add64(integral_sum, neg_offset) : integral_sum;

  // running sums, cleared after the last point
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      peak_magnitude <= '0;
    end else if (cmd.accum && !fixed_point_flag) begin
      integral_sum <= sat_add64(integral_sum, prod);
      if (mag > peak_magnitude) begin
        peak_magnitude <= mag;
      end
    end else if (cmd.out_load && last_point) begin
      integral_sum   <= '0;
      peak_magnitude <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata    <= {{(M_TDATA_W-DATA_W-MAG_W-ACC_W){1'b0}}, result, peak_magnitude, disp};
      m_tuser[0] <= side;
      m_tlast    <= last_point;
    end
  end

endmodule

// ===== rtl/boundary_displacement_integrator_unit.sv =====
// top level of the boundary displacement integrator
//
//  channel  | direction | handshake           | payload
//  s_*      | in        | s_tvalid / s_tready | one boundary point
//  m_*      | out       | m_tvalid / m_tready | displacement, peak and integral
//  cfg_*    | in        | cfg_we              | register index and write data
//
// after a request is accepted, six products run in series through one shared 32x32
// multiplier, with clamp, operand load, accumulate and output steps
// a new point is taken only after the previous one reached the output register,
// so the unit never works on more than one point at a time
// a result held by m_tready low stalls the sequencer in its output step only
// synchronous reset clears the sums and the handshake state, configuration registers go to reset values
module boundary_displacement_integrator_unit import bdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sens_objective, sens_first, sens_second, seg_length, low_limit, zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // fixed_point_flag, domain_flag
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // displacement, largest_magnitude, integral_value, zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  // side_limited
  output logic [0:0]            m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  bdi_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer
  bdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // arithmetic and result register
  bdi_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// ===== tb/displacement_integral_checker.sv =====
// watches the point and result streams, predicts each result and compares it field by field
module displacement_integral_checker import bdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [0:0]            m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam longint LONG_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN  = 64'sh8000_0000_0000_0000;
  localparam int     PRINT_MAX = 50;

  // one predicted result
  typedef struct {
    logic [31:0] disp;
    logic        side;
    logic [30:0] peak;
    logic [63:0] integral;
    logic        final_pt;
  } point_result_t;

  point_result_t displacement_q[$];

  // register shadow
  logic [31:0] w_obj, w_first, w_second, scale, offset;
  logic [16:0] limit;
  logic        cap_on;
  int_sel_t    int_select;

  // running sums across one boundary
  longint integral_acc;
  longint peak_acc;

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // fixed-point product, truncated toward zero
  function automatic longint fx_mul(input longint x, input longint y);
    return (x * y) / ONE_Q;
  endfunction

  function automatic longint clip_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint add_clipped(input longint a, input longint b);
    if (b > 0 && a > LONG_MAX - b) return LONG_MAX;
    if (b < 0 && a < LONG_MIN - b) return LONG_MIN;
    return a + b;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_MAX) begin
      $display("result %0d: %s is %h, predicted %h", checked, field, got, want);
    end
    mismatches++;
  endtask

  // displacement, clamps and integral contribution of one boundary point
  task automatic integrate_point(input logic [S_TDATA_W-1:0] d, input logic [S_TUSER_W-1:0] u,
                                 input logic last_pt, output point_result_t r);
    longint s_obj, s_first, s_second, len, low;
    longint wide, disp, mag, chosen, a, b, total;
    logic   side;
    s_obj    = sx(d[31:0]);
    s_first  = sx(d[63:32]);
    s_second = sx(d[95:64]);
    len      = longint'(d[126:96]);
    low      = sx(d[158:127]);
    disp     = 0;
    side     = 1'b0;
    if (!u[0]) begin
      wide = fx_mul(sx(w_obj), s_obj);
      if (NUM_FUNCS >= 2) wide += fx_mul(sx(w_first), s_first);
      if (NUM_FUNCS >= 3) wide += fx_mul(sx(w_second), s_second);
      // domain edge clamp from below, then the upper cap
      if (u[1] && wide < low) begin
        wide = low;
        side = 1'b1;
      end
      if (cap_on && wide > longint'(limit)) wide = longint'(limit);
      disp = clip_word(wide);
      mag = disp < 0 ? -disp : disp;
      if (mag > WORD_MAX) mag = WORD_MAX;
      if (mag > peak_acc) peak_acc = mag;
      case (int_select)
        SEL_OBJECTIVE: chosen = s_obj;
        SEL_FIRST:     chosen = s_first;
        SEL_SECOND:    chosen = s_second;
        default:       chosen = 0;
      endcase
      a = clip_word(fx_mul(sx(scale), disp));
      b = clip_word(fx_mul(chosen, len));
      integral_acc = add_clipped(integral_acc, a * b);
    end
    total = last_pt ? add_clipped(integral_acc, -(sx(offset) * ONE_Q)) : integral_acc;
    r.disp     = disp[31:0];
    r.side     = side;
    r.peak     = peak_acc[30:0];
    r.integral = total;
    r.final_pt = last_pt;
    if (last_pt) begin
      integral_acc = 0;
      peak_acc     = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    point_result_t want;
    if (rst) begin
      displacement_q.delete();
      integral_acc = 0;
      peak_acc     = 0;
      w_obj        = '0;
      w_first      = '0;
      w_second     = '0;
      limit        = MOVE_LIMIT_RESET;
      cap_on       = 1'b0;
      scale        = SCALE_RESET;
      offset       = '0;
      int_select   = SEL_OBJECTIVE;
      mismatches   = 0;
      checked      = 0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (displacement_q.size() == 0) begin
          report_mismatch("result with no point pending", m_tdata[63:0], 64'd0);
        end else begin
          want = displacement_q.pop_front();
          if (m_tdata[31:0] !== want.disp)
            report_mismatch("displacement", 64'(m_tdata[31:0]), 64'(want.disp));
          if (m_tuser[0] !== want.side)
            report_mismatch("side_limited", 64'(m_tuser[0]), 64'(want.side));
          if (m_tdata[62:32] !== want.peak)
            report_mismatch("largest_magnitude", 64'(m_tdata[62:32]), 64'(want.peak));
          if (m_tdata[126:63] !== want.integral)
            report_mismatch("integral_value", m_tdata[126:63], want.integral);
          if (m_tlast !== want.final_pt)
            report_mismatch("final_flag", 64'(m_tlast), 64'(want.final_pt));
        end
        checked++;
      end
      // predict each accepted request
      if (s_tvalid && s_tready) begin
        integrate_point(s_tdata, s_tuser, s_tlast, want);
        displacement_q.insert(displacement_q.size(), want);
      end
      // register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_WEIGHT_OBJECTIVE: w_obj      = cfg_wdata;
          REG_WEIGHT_FIRST:     w_first    = cfg_wdata;
          REG_WEIGHT_SECOND:    w_second   = cfg_wdata;
          REG_MOVE_LIMIT:       limit      = cfg_wdata[16:0];
          REG_CAP_ENABLE:       cap_on     = cfg_wdata[0];
          REG_INTEGRAL_SCALE:   scale      = cfg_wdata;
          REG_INTEGRAL_OFFSET:  offset     = cfg_wdata;
          REG_INTEGRAL_SELECT:  int_select = int_sel_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
    end
    outstanding <= displacement_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the integrator testbench: clock, reset, register settings, point stream and verdict
module testbench import bdi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TARGET_POINTS = 1620;
  localparam int SETTLE_CYCLES = 24;

  // one boundary point as sent
  typedef struct {
    logic [31:0] s_obj;
    logic [31:0] s_first;
    logic [31:0] s_second;
    logic [30:0] len;
    logic [31:0] low;
    logic        fixed_pt;
    logic        domain;
    logic        last_pt;
  } point_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [S_TUSER_W-1:0]  s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  int mismatches;
  int outstanding;
  int checked;
  int points_sent;
  int boundaries_sent;
  int settings_applied;
  bit steady_stream;

  boundary_displacement_integrator_unit i_dut (.*);

  displacement_integral_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", outstanding);
    $display("[boundary_displacement_integrator_unit] ERROR");
    $finish;
  end

  // result side back-pressure: short and long stalls, short and long open stretches
  initial begin
    int r;
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 24);
      end else if (r < 90) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 3);
      end else if (r < 96) begin
        m_tready <= 1'b1;
        n = $urandom_range(100, 300);
      end else begin
        m_tready <= 1'b0;
        n = $urandom_range(15, 60);
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic point_t mk_point(input logic [31:0] s0, input logic [31:0] s1,
                                      input logic [31:0] s2, input logic [30:0] len,
                                      input logic [31:0] low, input logic fixed_pt,
                                      input logic domain, input logic last_pt);
    point_t p;
    p.s_obj    = s0;
    p.s_first  = s1;
    p.s_second = s2;
    p.len      = len;
    p.low      = low;
    p.fixed_pt = fixed_pt;
    p.domain   = domain;
    p.last_pt  = last_pt;
    return p;
  endfunction

  function automatic cfg_t mk_settings(input logic [31:0] wo, input logic [31:0] wf,
                                       input logic [31:0] ws, input logic [16:0] limit,
                                       input logic cap, input logic [31:0] scale,
                                       input logic [31:0] offset, input int_sel_t sel);
    cfg_t c;
    c.weight_objective = wo;
    c.weight_first     = wf;
    c.weight_second    = ws;
    c.move_limit       = limit;
    c.cap_enable       = cap;
    c.integral_scale   = scale;
    c.integral_offset  = offset;
    c.integral_select  = sel;
    return c;
  endfunction

  // mostly small Q16.16 values, some full range, a few extremes
  function automatic logic [31:0] rand_word();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      v = $urandom_range(0, 32'h0004_0000);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 9) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  function automatic point_t random_point(input bit last_pt);
    point_t p;
    int r;
    p.s_obj    = rand_word();
    p.s_first  = rand_word();
    p.s_second = rand_word();
    r = $urandom_range(0, 9);
    p.len = (r < 8) ? 31'($urandom_range(0, 32'h0004_0000)) : 31'($urandom);
    r = $urandom_range(0, 9);
    if (r < 7) p.low = 32'd0 - 32'($urandom_range(0, 32'h0003_0000));
    else if (r < 9) p.low = $urandom;
    else p.low = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
    p.fixed_pt = ($urandom_range(0, 7) == 0);
    p.domain   = 1'($urandom_range(0, 1));
    p.last_pt  = last_pt;
    return p;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.weight_objective = rand_word();
    c.weight_first     = rand_word();
    c.weight_second    = rand_word();
    case ($urandom_range(0, 5))
      0:       c.move_limit = 17'h0_0000;
      1:       c.move_limit = 17'h1_0000;
      2:       c.move_limit = 17'h1_FFFF;
      default: c.move_limit = 17'($urandom_range(0, 32'h0001_0000));
    endcase
    c.cap_enable      = 1'($urandom_range(0, 1));
    c.integral_scale  = ($urandom_range(0, 3) == 0) ? rand_word()
                                                    : 32'($urandom_range(0, 32'h0002_0000));
    c.integral_offset = rand_word();
    c.integral_select = int_sel_t'($urandom_range(0, 3));
    return c;
  endfunction

  // send one point request, then an optional gap
  task automatic send_point(input point_t p);
    int r;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({p.low, p.len, p.s_second, p.s_first, p.s_obj});
    s_tuser  <= {p.domain, p.fixed_pt};
    s_tlast  <= p.last_pt;
    do @(posedge clk); while (!s_tready);
    points_sent++;
    if (p.last_pt) boundaries_sent++;
    if (!steady_stream) begin
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off requests until every predicted result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    cfg_write(REG_WEIGHT_OBJECTIVE, c.weight_objective);
    cfg_write(REG_WEIGHT_FIRST, c.weight_first);
    cfg_write(REG_WEIGHT_SECOND, c.weight_second);
    cfg_write(REG_MOVE_LIMIT, 32'(c.move_limit));
    cfg_write(REG_CAP_ENABLE, 32'(c.cap_enable));
    cfg_write(REG_INTEGRAL_SCALE, c.integral_scale);
    cfg_write(REG_INTEGRAL_OFFSET, c.integral_offset);
    cfg_write(REG_INTEGRAL_SELECT, 32'(c.integral_select));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // stimulus
  initial begin
    int n;
    int len;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    steady_stream = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register values out of reset
    send_point(mk_point(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000, 31'h0001_0000,
                        32'hFFFF_0000, 1'b0, 1'b1, 1'b1));
    drain();

    // weights 1, -0.5, 0.25, cap at one half, integral over first constraint
    apply_settings(mk_settings(32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000, 17'h0_8000,
                               1'b1, 32'h0001_0000, 32'h0001_0000, SEL_FIRST));
    // all zero
    send_point(mk_point('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
    // largest positive fields, smallest low limit
    send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0, 1'b1, 1'b0));
    // most negative sensitivities clamped at the side limit
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0,
                        32'hFFFF_0000, 1'b0, 1'b1, 1'b0));
    // fixed point leaves the sums alone
    send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b1, 1'b1, 1'b0));
    // domain point above its limit
    send_point(mk_point(32'h0000_4000, 32'h0, 32'h0, 31'h0002_0000,
                        32'hFFFF_0000, 1'b0, 1'b1, 1'b0));
    // below the limit but not near the domain edge
    send_point(mk_point(32'hFFFE_0000, 32'h0, 32'h0, 31'h0001_0000,
                        32'hFFFF_0000, 1'b0, 1'b0, 1'b0));
    // capped from above
    send_point(mk_point(32'h0003_0000, 32'h0002_0000, 32'h0004_0000, 31'h0001_8000,
                        32'hFFFF_0000, 1'b0, 1'b0, 1'b0));
    // positive low limit: clamp up, then cap
    send_point(mk_point(32'h0, 32'h0, 32'h0, 31'h0001_0000,
                        32'h0001_0000, 1'b0, 1'b1, 1'b0));
    // end of boundary with offset
    send_point(mk_point(32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 31'h0001_0000,
                        32'hFFFF_0000, 1'b0, 1'b0, 1'b1));
    // fixed point that ends a boundary
    send_point(mk_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000,
                        32'hFFFF_0000, 1'b1, 1'b0, 1'b1));
    // one-point boundary with a saturated length product
    send_point(mk_point(32'h0000_8000, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF,
                        32'hFFFF_0000, 1'b0, 1'b0, 1'b1));
    drain();

    // most negative weights and scale, nothing selected for the integral
    apply_settings(mk_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'h1_FFFF,
                               1'b0, 32'h8000_0000, 32'h7FFF_FFFF, SEL_NONE));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0, 1'b1, 1'b0));
    send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0, 1'b1, 1'b0));
    send_point(mk_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000,
                        32'h0, 1'b0, 1'b0, 1'b1));
    drain();

    // integral driven into negative saturation
    apply_settings(mk_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'h0_0000,
                               1'b0, 32'h7FFF_FFFF, 32'h8000_0000, SEL_OBJECTIVE));
    repeat (3) send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   31'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0, 1'b0, 1'b1));
    drain();

    // integral driven into positive saturation
    apply_settings(mk_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1_0000,
                               1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, SEL_SECOND));
    repeat (2) send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   31'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 1'b0, 1'b0, 1'b1));

    // random settings, each followed by several random boundaries
    while (points_sent < TARGET_POINTS) begin
      drain();
      apply_settings(random_settings());
      steady_stream = ($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 16);
      repeat (n) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_point(random_point(i == len - 1));
          if ($urandom_range(0, 199) == 0) drain();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d points in %0d boundaries under %0d register settings",
             points_sent, boundaries_sent, settings_applied);
    $display("compared %0d results, %0d field mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("[boundary_displacement_integrator_unit] OK");
    end else begin
      $display("[boundary_displacement_integrator_unit] ERROR");
    end
    $finish;
  end

endmodule
